// ----- design/utf8_stream_decoder_core_assert.svh -----
// Assertion macros used by the checker file of the UTF-8 decoder.
`ifndef UTF8_STREAM_DECODER_CORE_ASSERT_SVH
`define UTF8_STREAM_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, quiet during reset.
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, quiet during reset.
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/utf8d_pkg.sv -----
// Shared types and constants of the UTF-8 stream decoder.
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int CP_W = 21;

    // Replacement character emitted for malformed input.
    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Queue between the classifier and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One decoded result as it leaves the block.
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            malformed;
        logic            run_last;
        logic            string_done;
    } result_t;

    // All results caused by one input byte: one or two.
    typedef struct packed {
        result_t first;
        result_t second;
        logic    has_second;
    } job_t;

endpackage

// ----- design/utf8d_front.sv -----
// Byte classifier: keeps the open-sequence state and builds the results of each byte.
`timescale 1ns / 1ps

module utf8d_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        byte_req,
    input  logic              string_end,
    input  logic              queue_full,
    output logic              push,
    output utf8d_pkg::job_t   push_job
);

    logic [utf8d_pkg::CP_W-1:0] partial_reg;
    logic [utf8d_pkg::CP_W-1:0] partial_next;
    logic [1:0]                 pending_reg;
    logic [1:0]                 pending_next;
    logic [1:0]                 count;
    utf8d_pkg::result_t         res0;
    utf8d_pkg::result_t         res1;
    logic                       accept;

    function automatic utf8d_pkg::result_t mk_res(input logic [utf8d_pkg::CP_W-1:0] cp,
                                                  input logic bad);
        utf8d_pkg::result_t r;
        r.code_point  = cp;
        r.malformed   = bad;
        r.run_last    = 1'b0;
        r.string_done = 1'b0;
        return r;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && !queue_full;

    // Decode one byte into at most two results and the next sequence state.
    always_comb
    begin
        utf8d_pkg::result_t r;
        partial_next = partial_reg;
        pending_next = pending_reg;
        count        = 2'd0;
        res0         = mk_res(utf8d_pkg::REPLACEMENT_CP, 1'b1);
        res1         = mk_res(utf8d_pkg::REPLACEMENT_CP, 1'b1);
        r            = mk_res(utf8d_pkg::REPLACEMENT_CP, 1'b1);

        if (pending_reg != 2'd0 && byte_req[7:6] == 2'b10)
        begin
            // Continuation byte shifts in six more bits.
            partial_next = {partial_reg[utf8d_pkg::CP_W-7:0], byte_req[5:0]};
            pending_next = pending_reg - 2'd1;
            if (pending_next == 2'd0)
            begin
                res0  = mk_res(partial_next, 1'b0);
                count = 2'd1;
            end
        end
        else
        begin
            // An open sequence cut short by a non-continuation byte.
            if (pending_reg != 2'd0)
            begin
                res0         = mk_res(utf8d_pkg::REPLACEMENT_CP, 1'b1);
                count        = 2'd1;
                pending_next = 2'd0;
                partial_next = '0;
            end
            // The byte itself is decoded as a lead byte.
            case (byte_req) inside
                [8'h00:8'h7F]:
                begin
                    r = mk_res({13'd0, byte_req}, 1'b0);
                    if (count == 2'd0)
                        res0 = r;
                    else
                        res1 = r;
                    count = count + 2'd1;
                end
                [8'hC0:8'hDF]:
                begin
                    partial_next = {16'd0, byte_req[4:0]};
                    pending_next = 2'd1;
                end
                [8'hE0:8'hEF]:
                begin
                    partial_next = {17'd0, byte_req[3:0]};
                    pending_next = 2'd2;
                end
                [8'hF0:8'hF7]:
                begin
                    partial_next = {18'd0, byte_req[2:0]};
                    pending_next = 2'd3;
                end
                default:
                begin
                    // Stray continuation or invalid lead byte.
                    if (count == 2'd0)
                        res0 = r;
                    else
                        res1 = r;
                    count = count + 2'd1;
                end
            endcase
        end

        // A sequence still open at string end is closed with a replacement.
        if (string_end && pending_next != 2'd0)
        begin
            if (count == 2'd0)
                res0 = mk_res(utf8d_pkg::REPLACEMENT_CP, 1'b1);
            else
                res1 = mk_res(utf8d_pkg::REPLACEMENT_CP, 1'b1);
            count        = count + 2'd1;
            pending_next = 2'd0;
            partial_next = '0;
        end

        // Mark the last result of this byte, and of the string.
        if (count == 2'd1)
        begin
            res0.run_last    = 1'b1;
            res0.string_done = string_end;
        end
        else if (count == 2'd2)
        begin
            res1.run_last    = 1'b1;
            res1.string_done = string_end;
        end
    end

    assign push                = accept && (count != 2'd0);
    assign push_job.first      = res0;
    assign push_job.second     = res1;
    assign push_job.has_second = (count == 2'd2);

    // Sequence state advances on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            pending_reg <= 2'd0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// ----- design/utf8d_queue.sv -----
// Short queue of per-byte result groups between the classifier and the output stage.
`timescale 1ns / 1ps

module utf8d_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  utf8d_pkg::job_t   push_job,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output utf8d_pkg::job_t   head_job
);

    utf8d_pkg::job_t               mem_reg [utf8d_pkg::QUEUE_DEPTH];
    logic [utf8d_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [utf8d_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [utf8d_pkg::QCNT_W-1:0]  count_reg;
    logic [utf8d_pkg::QCNT_W-1:0]  count_next;

    assign full      = (count_reg == utf8d_pkg::QCNT_W'(utf8d_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_job  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + utf8d_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - utf8d_pkg::QCNT_W'(1);
    end

    // Storage is written at the tail only.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == utf8d_pkg::QPTR_W'(utf8d_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + utf8d_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == utf8d_pkg::QPTR_W'(utf8d_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + utf8d_pkg::QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/utf8d_back.sv -----
// Output stage: registers results and emits one group's results one per transfer.
`timescale 1ns / 1ps

module utf8d_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    input  utf8d_pkg::job_t             job,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [utf8d_pkg::CP_W-1:0]  code_point,
    output logic                        malformed,
    output logic                        run_last,
    output logic                        string_done
);

    logic               cur_valid_reg;
    utf8d_pkg::result_t cur_reg;
    logic               sec_valid_reg;
    utf8d_pkg::result_t sec_reg;
    logic               cur_free;

    // The current slot frees when empty or when its result is taken.
    assign cur_free = !cur_valid_reg || out_ready;
    assign pop      = cur_free && !sec_valid_reg && job_valid;

    assign out_valid   = cur_valid_reg;
    assign code_point  = cur_reg.code_point;
    assign malformed   = cur_reg.malformed;
    assign run_last    = cur_reg.run_last;
    assign string_done = cur_reg.string_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            sec_valid_reg <= 1'b0;
        end
        else if (cur_free)
        begin
            if (sec_valid_reg)
            begin
                cur_valid_reg <= 1'b1;
                sec_valid_reg <= 1'b0;
            end
            else
            begin
                cur_valid_reg <= job_valid;
                sec_valid_reg <= job_valid && job.has_second;
            end
        end
    end

    // Payload moves from the second slot or from the queue head.
    always_ff @(posedge clk)
    begin
        if (cur_free)
        begin
            if (sec_valid_reg)
            begin
                cur_reg <= sec_reg;
            end
            else if (job_valid)
            begin
                cur_reg <= job.first;
                sec_reg <= job.second;
            end
        end
    end

endmodule

// ----- design/utf8_stream_decoder_core.sv -----
// UTF-8 stream decoder: one byte in, zero to two code points out.
// A byte's first result is written into the queue, then into the output register, which drives the output.
// Throughput: one byte per cycle while the queue is not full; a byte that gives two results holds the output for both.
// The four-entry queue lets input keep flowing while a two-result byte drains.
// Reset (rst_n low, asynchronous) closes any open sequence and empties queue and output.
`timescale 1ns / 1ps

module utf8_stream_decoder_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  byte_req,
    input  logic                        string_end,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [utf8d_pkg::CP_W-1:0]  code_point,
    output logic                        malformed,
    output logic                        run_last,
    output logic                        string_done
);

    logic            push;
    utf8d_pkg::job_t push_job;
    logic            queue_full;
    logic            pop;
    logic            job_valid;
    utf8d_pkg::job_t head_job;

    // Classifier with the open-sequence state.
    utf8d_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_req   (byte_req),
        .string_end (string_end),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    // Decoupling queue.
    utf8d_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (job_valid),
        .head_job  (head_job)
    );

    // Registered output stage.
    utf8d_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (head_job),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_point  (code_point),
        .malformed   (malformed),
        .run_last    (run_last),
        .string_done (string_done)
    );

endmodule

// ----- design/utf8d_checker.sv -----
// Port-level checks on the UTF-8 decoder, bound to the top level.
`timescale 1ns / 1ps
`include "utf8_stream_decoder_core_assert.svh"

module utf8d_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [7:0]                  byte_req,
    input  logic                        string_end,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [utf8d_pkg::CP_W-1:0]  code_point,
    input  logic                        malformed,
    input  logic                        run_last,
    input  logic                        string_done
);

    // A waiting input byte keeps its payload until the transfer.
    `UTF8D_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(byte_req) && $stable(string_end), "waiting byte changed")

    // A stalled result keeps its code point and run_last flag.
    `UTF8D_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(run_last), "stalled result changed")

    // The final result of a string is also the last result of its byte.
    `UTF8D_ASSERT_NOW(a_done_last, out_valid && string_done, run_last, "string_done without run_last")

    // A malformed result always carries the replacement character.
    `UTF8D_ASSERT_NOW(a_bad_cp, out_valid && malformed, code_point == utf8d_pkg::REPLACEMENT_CP, "malformed result is not U+FFFD")

    // A result that is not last of its byte is a replacement for an interrupted sequence.
    `UTF8D_ASSERT_NOW(a_first_bad, out_valid && !run_last, malformed && !string_done, "leading result of a byte not malformed")

endmodule

bind utf8_stream_decoder_core utf8d_checker u_utf8d_checker (.*);
